>>> rtl/pie_pkg.sv
// Package for the palette index expander: shared constants, codes and the
// queue item type passed from the front end to the back end.
// No dependencies.
package pie_pkg;

  localparam int PaletteEntriesDefault = 256;
  localparam int QDepth = 4;
  localparam int QAw = 2;
  localparam int OutDepth = 4;
  localparam int OutAw = 2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    DEPTH_8 = 2'd0,
    DEPTH_4 = 2'd1,
    DEPTH_1 = 2'd2
  } depth_mode_t;

  typedef struct packed {
    logic        is_load;
    logic        load_ok;
    depth_mode_t mode;
    logic [7:0]  entry;
    logic [23:0] rgb;
    logic [7:0]  packed_indices;
  } q_item_t;

endpackage

>>> rtl/pie_front.sv
// Front end: accepts input beats, decodes the kind and the depth mode,
// and range-checks load entries. Depends on pie_pkg.
module pie_front import pie_pkg::*; #(
  parameter int PALETTE_ENTRIES = PaletteEntriesDefault
) (
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        in_tuser,
  input  logic [1:0]  index_depth,
  input  logic        q_full,
  output logic        q_push,
  output q_item_t     q_item
);

  localparam logic [8:0] EntryLimit = 9'(PALETTE_ENTRIES);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item                = '0;
    q_item.is_load        = (in_tuser == FUNC_LOAD);
    q_item.entry          = in_tdata[7:0];
    q_item.rgb            = in_tdata[31:8];
    q_item.packed_indices = in_tdata[39:32];
    q_item.load_ok        = ({1'b0, in_tdata[7:0]} < EntryLimit);
    case (index_depth)
      2'd0: begin
        q_item.mode = DEPTH_8;
      end
      2'd1: begin
        q_item.mode = DEPTH_4;
      end
      default: begin
        // depth code three behaves as one bit per index
        q_item.mode = DEPTH_1;
      end
    endcase
  end

endmodule

>>> rtl/pie_queue.sv
// Short FIFO between front end and back end.
// Depends on pie_pkg for the item type and depth.
module pie_queue import pie_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output q_item_t head_item
);

  q_item_t          slot_r [QDepth];
  logic [QAw-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAw-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAw:0]     cnt_r, cnt_nxt;

  assign full       = (cnt_r == (QAw+1)'(QDepth));
  assign head_valid = (cnt_r != '0);
  assign head_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAw'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QAw'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (QAw+1)'(push) - (QAw+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/pie_back.sv
// Back end: palette memory, per-pixel sequencer, registered palette read
// and output FIFO. Depends on pie_pkg.
module pie_back import pie_pkg::*; #(
  parameter int PALETTE_ENTRIES = PaletteEntriesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  q_item_t     q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tlast
);

  localparam int Aw = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [8:0] IdxLimit = 9'(PALETTE_ENTRIES);

  logic [23:0]       pal_mem [PALETTE_ENTRIES];
  logic [2:0]        k_r, k_nxt;
  logic [2:0]        last_k;
  logic [7:0]        idx;
  logic              in_range;
  logic              credit_ok;
  logic              do_load;
  logic              issue;
  logic              end_of_byte;

  logic              infl_r;
  logic              black_r;
  logic              plast_r;
  logic [23:0]       rdata_r;

  logic [24:0]       ofifo_r [OutDepth];
  logic [OutAw-1:0]  owr_r, ord_r;
  logic [OutAw:0]    ocnt_r, ocnt_nxt;
  logic              opush, opop;

  always_comb begin
    case (q_item.mode)
      DEPTH_8: begin
        last_k = 3'd0;
        idx    = q_item.packed_indices;
      end
      DEPTH_4: begin
        last_k = 3'd1;
        // high nibble first
        idx    = k_r[0] ? {4'b0, q_item.packed_indices[3:0]}
                        : {4'b0, q_item.packed_indices[7:4]};
      end
      default: begin
        last_k = 3'd7;
        idx    = {7'b0, q_item.packed_indices[3'd7 - k_r]};
      end
    endcase
  end

  assign in_range    = ({1'b0, idx} < IdxLimit);
  // hold issue until the output FIFO has room for everything in flight
  assign credit_ok   = ((OutAw+1)'(ocnt_r) + (OutAw+1)'(infl_r)) < (OutAw+1)'(OutDepth);
  assign do_load     = q_valid && q_item.is_load;
  assign issue       = q_valid && !q_item.is_load && credit_ok;
  assign end_of_byte = (k_r == last_k);
  assign q_pop       = do_load || (issue && end_of_byte);

  always_comb begin
    k_nxt = k_r;
    if (issue) begin
      k_nxt = end_of_byte ? 3'd0 : k_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load && q_item.load_ok) begin
      pal_mem[q_item.entry[Aw-1:0]] <= q_item.rgb;
    end
    if (issue) begin
      rdata_r <= pal_mem[idx[Aw-1:0]];
      black_r <= !in_range;
      plast_r <= end_of_byte;
    end
  end

  assign opush = infl_r;
  assign opop  = out_tvalid && out_tready;

  always_comb begin
    ocnt_nxt = ocnt_r + (OutAw+1)'(opush) - (OutAw+1)'(opop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= '0;
      infl_r <= 1'b0;
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      k_r    <= k_nxt;
      infl_r <= issue;
      ocnt_r <= ocnt_nxt;
      if (opush) begin
        owr_r <= owr_r + OutAw'(1);
      end
      if (opop) begin
        ord_r <= ord_r + OutAw'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      // drop the palette data for indices past the store
      ofifo_r[owr_r] <= {plast_r, (black_r ? 24'd0 : rdata_r)};
    end
  end

  assign out_tvalid = (ocnt_r != '0);
  assign out_tdata  = ofifo_r[ord_r][23:0];
  assign out_tlast  = ofifo_r[ord_r][24];

endmodule

>>> rtl/palette_index_expander.sv
// Top level of the palette index expander: config register, front end,
// queue and back end. Depends on pie_pkg, pie_front, pie_queue, pie_back.
//
//   channel  dir  tdata (low bit up)                         tuser / tlast
//   in_      in   entry, load_red, load_green, load_blue,    tuser = func
//                 packed_indices (40 bits)
//   out_     out  pixel_red, pixel_green, pixel_blue (24)    tlast = last_of_byte
//   cfg_     in   cfg_wdata = index_depth (2 bits)           cfg_we strobe
//
// A load beat writes at most one palette entry; a pixel beat makes one, two
// or eight palette reads, one per output pixel on the single read port, each
// issued only while the output FIFO has room. out_tvalid for the first pixel
// rises after the beat passes the queue, the registered palette read and the FIFO.
// Reset clears the control state and sets index_depth to eight bits; the
// palette is not cleared. A four-entry queue and a four-entry output FIFO let
// the input side keep accepting while the output side stalls.
module palette_index_expander import pie_pkg::*; #(
  parameter int PALETTE_ENTRIES = PaletteEntriesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // entry, load_red, load_green, load_blue, packed_indices
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pixel_red, pixel_green, pixel_blue
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  logic [1:0] depth_r;
  logic       q_full;
  logic       q_push;
  q_item_t    q_in_item;
  logic       q_pop;
  logic       q_valid;
  q_item_t    q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= 2'd0;
    end else if (cfg_we) begin
      depth_r <= cfg_wdata;
    end
  end

  pie_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .index_depth(depth_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_in_item)
  );

  pie_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_item (q_head)
  );

  pie_back #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

>>> rtl/pie_checker.sv
// Port-level checker for the palette index expander, bound to the top level.
// Depends on the top level's port names only.
module pie_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [1:0]  cfg_wdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  logic [1:0] depth_r;
  logic [2:0] beat_r;
  logic [2:0] exp_last;
  logic       out_fire;

  assign out_fire = out_tvalid && out_tready;

  always_comb begin
    case (depth_r)
      2'd0: begin
        exp_last = 3'd0;
      end
      2'd1: begin
        exp_last = 3'd1;
      end
      default: begin
        exp_last = 3'd7;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= 2'd0;
      beat_r  <= 3'd0;
    end else begin
      if (cfg_we) begin
        depth_r <= cfg_wdata;
      end
      if (out_fire) begin
        beat_r <= out_tlast ? 3'd0 : beat_r + 3'd1;
      end
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output beat changed");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_tlast |-> beat_r == exp_last)
    else $error("tlast at wrong pixel position");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_tlast |-> beat_r < exp_last)
    else $error("missing tlast on final pixel of byte");

endmodule

bind palette_index_expander pie_checker u_pie_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_we    (cfg_we),
  .cfg_wdata (cfg_wdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

>>> tb/sv/pie_checker.sv
// Checker for the palette index expander: watches the input, output and config
// ports, predicts every expanded pixel and compares it with what comes out.
// Depends on pie_pkg.
`timescale 1ns / 100ps

module pie_tb_checker import pie_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // entry, load_red, load_green, load_blue, packed_indices
  input  logic        in_tuser,   // func
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // pixel_red, pixel_green, pixel_blue
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  output int          mismatch_count,
  output int          pixels_due
);

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } pixel_t;

  // {blue, green, red} per entry, same layout as the output beat
  logic [23:0] palette_copy [PaletteEntriesDefault];
  logic [1:0]  depth_sel;
  pixel_t      pixels_expected [$];

  initial begin
    mismatch_count = 0;
    pixels_due = 0;
    depth_sel = DEPTH_8;
    foreach (palette_copy[i]) palette_copy[i] = '0;
  end

  function automatic pixel_t color_of(input logic [7:0] idx, input logic last);
    return {palette_copy[idx], last};
  endfunction

  task automatic expand_byte(input logic [7:0] packed_byte);
    case (depth_sel)
      DEPTH_8: begin
        pixels_expected.push_back(color_of(packed_byte, 1'b1));
      end
      DEPTH_4: begin
        pixels_expected.push_back(color_of({4'h0, packed_byte[7:4]}, 1'b0));
        pixels_expected.push_back(color_of({4'h0, packed_byte[3:0]}, 1'b1));
      end
      default: begin
        // one-bit indices, msb first; code three behaves the same
        for (int i = 7; i >= 0; i--)
          pixels_expected.push_back(color_of({7'd0, packed_byte[i]}, i == 0));
      end
    endcase
  endtask

  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    if (!rst_n) begin
      depth_sel = DEPTH_8;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata, out_tlast};
        if (pixels_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected pixel r=%02h g=%02h b=%02h last=%0b", $time,
                     got.red, got.green, got.blue, got.last);
        end else begin
          want = pixels_expected.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch exp rgb=%02h_%02h_%02h l=%0b got rgb=%02h_%02h_%02h l=%0b",
                       $time, want.red, want.green, want.blue, want.last,
                       got.red, got.green, got.blue, got.last);
          end
        end
      end
      if (cfg_we) depth_sel = cfg_wdata;
      if (in_tvalid && in_tready) begin
        if (in_tuser == FUNC_LOAD) palette_copy[in_tdata[7:0]] = in_tdata[31:8];
        else expand_byte(in_tdata[39:32]);
      end
    end
    pixels_due = pixels_expected.size();
  end

endmodule

>>> tb/sv/tb_palette_index_expander.sv
// Testbench top for the palette index expander: clock, reset, load and pixel
// stimulus, output back-pressure and the verdict. Depends on pie_pkg,
// pie_tb_checker and palette_index_expander.
`timescale 1ns / 100ps

module tb_palette_index_expander;
  import pie_pkg::*;

  localparam logic [1:0] DEPTH_1_ALT = 2'd3;  // spare depth code, one bit per index
  localparam int SettleCycles = 16;
  localparam int PhaseItems = 33;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // entry, load_red, load_green, load_blue, packed_indices
  logic        in_tuser = FUNC_LOAD;  // func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // pixel_red, pixel_green, pixel_blue
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = DEPTH_8;

  int          mismatch_count;
  int          pixels_due;
  int          idle_pct = 20;
  int          stall_left = 0;
  logic [1:0]  cur_depth = DEPTH_8;
  bit          entry_loaded [256];
  logic [7:0]  loaded_list [$];

  always #4 clk = ~clk;

  palette_index_expander DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  pie_tb_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pixels_due     (pixels_due)
  );

  // output back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(1, 13) - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // hold the beat until accepted; valid stays high into the next beat unless a gap is drawn
  task automatic send_beat(input logic func, input logic [7:0] ent, input logic [7:0] red,
                           input logic [7:0] green, input logic [7:0] blue,
                           input logic [7:0] packed_byte);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {packed_byte, blue, green, red, ent};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic load_entry(input logic [7:0] ent, input logic [7:0] red,
                            input logic [7:0] green, input logic [7:0] blue);
    if (!entry_loaded[ent]) loaded_list.push_back(ent);
    entry_loaded[ent] = 1'b1;
    send_beat(FUNC_LOAD, ent, red, green, blue, 8'($urandom));
  endtask

  task automatic send_pixels(input logic [7:0] packed_byte);
    send_beat(FUNC_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              packed_byte);
  endtask

  // wait out every pending pixel plus the tail of any trailing load
  task automatic drain_all();
    in_tvalid <= 1'b0;
    wait (pixels_due == 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_depth(input logic [1:0] depth);
    drain_all();
    cfg_we <= 1'b1;
    cfg_wdata <= depth;
    cur_depth = depth;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random byte whose indices all point at loaded entries
  function automatic logic [7:0] legal_byte();
    logic [7:0] b;
    logic [3:0] hi;
    logic [3:0] lo;
    b = 8'($urandom);
    if (cur_depth == DEPTH_8) begin
      if (!entry_loaded[b]) b = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    end else if (cur_depth == DEPTH_4) begin
      hi = b[7:4];
      lo = b[3:0];
      if (!entry_loaded[{4'h0, hi}]) hi = $urandom_range(0, 1) ? 4'hF : 4'h1;
      if (!entry_loaded[{4'h0, lo}]) lo = $urandom_range(0, 1) ? 4'h0 : 4'hF;
      b = {hi, lo};
    end
    return b;
  endfunction

  task automatic random_phase(input logic [1:0] depth, input int pct, input bit pause_mid);
    logic [7:0] ent;
    set_depth(depth);
    idle_pct = pct;
    for (int n = 0; n < PhaseItems; n++) begin
      if (pause_mid && n == PhaseItems / 2) drain_all();
      if ($urandom_range(0, 99) < 30) begin
        // favor the low entries that four- and one-bit modes read
        ent = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 15)) : 8'($urandom);
        load_entry(ent, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_pixels(legal_byte());
      end
    end
  endtask

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // eight-bit mode out of reset: extremes of the components and indices
    load_entry(8'd0, 8'h00, 8'h00, 8'h00);
    load_entry(8'd255, 8'hFF, 8'hFF, 8'hFF);
    load_entry(8'd1, 8'hAA, 8'h55, 8'h0F);
    load_entry(8'd128, 8'h5A, 8'hF0, 8'hA5);
    send_pixels(8'h00);
    send_pixels(8'hFF);
    send_pixels(8'h01);
    send_pixels(8'h80);

    set_depth(DEPTH_1);
    send_pixels(8'h00);
    send_pixels(8'hFF);
    send_pixels(8'hA5);
    send_pixels(8'h5A);

    set_depth(DEPTH_1_ALT);
    send_pixels(8'h96);

    set_depth(DEPTH_4);
    load_entry(8'd15, 8'h3C, 8'hC3, 8'h81);
    send_pixels(8'hF0);
    send_pixels(8'h0F);
    send_pixels(8'h1F);
    send_pixels(8'hF1);

    random_phase(DEPTH_1, 25, 1'b0);
    random_phase(DEPTH_8, 10, 1'b1);
    random_phase(DEPTH_4, 30, 1'b0);
    random_phase(DEPTH_1_ALT, 0, 1'b0);
    random_phase(DEPTH_8, 30, 1'b0);
    random_phase(DEPTH_4, 15, 1'b0);
    random_phase(DEPTH_1, 0, 1'b0);

    drain_all();
    if (mismatch_count == 0 && pixels_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
